// ===== rtl/sacache_pkg.sv =====
`default_nettype none

package sacache_pkg;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   // access kinds on req_op
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // configuration register indexes
   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_WAYS       = 2'd1;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd2;

   localparam int TAG_W = 32;

endpackage

`default_nettype wire

// ===== rtl/sacache_ram.sv =====
`default_nettype none

// simple dual-port RAM, registered read
module sacache_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_lru_sim_unit.sv =====
`default_nettype none

// Tag-only set-associative cache model with LRU replacement. Pulse start with
// req_op/req_address while busy is low; a load or store gives one result, a
// modify gives two (the second marked rsp_last), op 3 is dropped. Each access
// first reads the set's row from the line RAM, then picks hit/fill/victim,
// writes the row back and registers the result; no new item is accepted
// until the unit is idle again. Each result is held on the rsp_ ports
// for exactly one cycle with rsp_valid high and cannot be stalled.
// rsp_*_total are saturating running counts including that access.
// Configuration (set_bits, ways, block_bits) is taken through the csr_ port
// only while busy is low and no item is being started (csr_ready low
// otherwise); stored lines are kept across a change. No clearing pass: a
// per-set valid flop cleared by reset masks the stored valid bits of a row
// until that row is first written back.
module set_assoc_cache_lru_sim_unit #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_address,

   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic             rsp_evicted,
   output logic             rsp_last,
   output logic [31:0]      rsp_hit_total,
   output logic [31:0]      rsp_miss_total,
   output logic [31:0]      rsp_eviction_total,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_data
);

   localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ROWS   = 1 << MAX_SET_BITS;
   localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WI_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int NW_W   = $clog2(MAX_WAYS + 1);
   localparam int TAG_W  = sacache_pkg::TAG_W;
   localparam int WAY_W  = 1 + TAG_W + AGE_W;
   localparam int ROW_W  = MAX_WAYS * WAY_W;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

   // config registers
   logic [2:0] set_bits_ff;
   logic [3:0] ways_ff;
   logic [4:0] block_bits_ff;

   // control
   sacache_pkg::state_type state_ff, state_in;
   logic                   pending_ff, pending_in;   // second access of a modify
   logic [SET_W-1:0]       set_ff, set_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic [ROWS-1:0]        row_valid_ff;

   // counters double as the result totals
   logic [31:0] hit_count_ff, miss_count_ff, evict_count_ff;
   logic        rsp_valid_ff, rsp_hit_ff, rsp_evicted_ff, rsp_last_ff;

   // RAM interface
   logic             ram_rd_en;
   logic [SET_W-1:0] ram_rd_addr;
   logic             ram_wr_en;
   logic [ROW_W-1:0] ram_rd_data, ram_wr_data;

   // address split
   logic [2:0]  sb;
   logic [5:0]  tag_shift;
   logic [31:0] set_mask;

   // way evaluation
   logic [NW_W-1:0]  nw;
   logic             vld [MAX_WAYS];
   logic [TAG_W-1:0] tg  [MAX_WAYS];
   logic [AGE_W-1:0] ag  [MAX_WAYS];
   logic             found, have_empty, have_victim;
   logic [WI_W-1:0]  hit_w, empty_w, victim_w, chosen_w;
   logic [AGE_W-1:0] victim_age, bound;
   logic             bounded;
   logic             acc_hit, acc_evict;

   // geometry only changes with nothing in flight and no item being taken
   assign csr_ready = !busy && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd4;
         ways_ff       <= 4'd1;
         block_bits_ff <= 5'd4;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sacache_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_data[2:0];
            sacache_pkg::CSR_WAYS:       ways_ff       <= csr_data[3:0];
            sacache_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // set index and tag of the incoming address under current geometry
   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         sb = 3'(MAX_SET_BITS);
      end else begin
         sb = set_bits_ff;
      end
      set_mask  = (32'd1 << sb) - 32'd1;
      tag_shift = {3'b000, sb} + {1'b0, block_bits_ff};
      set_in    = SET_W'((req_address >> block_bits_ff) & set_mask);
      if (tag_shift >= 6'd32) begin
         tag_in = '0;
      end else begin
         tag_in = req_address >> tag_shift;
      end
   end

   always_comb begin
      if (ways_ff == 4'd0) begin
         nw = NW_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         nw = NW_W'(MAX_WAYS);
      end else begin
         nw = NW_W'(ways_ff);
      end
   end

   // unpack the row; rows never written since reset read as all invalid
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         ag[w]  = ram_rd_data[w*WAY_W +: AGE_W];
         tg[w]  = ram_rd_data[w*WAY_W + AGE_W +: TAG_W];
         vld[w] = ram_rd_data[w*WAY_W + AGE_W + TAG_W] & row_valid_ff[set_ff];
      end
   end

   // hit search, highest empty way, oldest valid way (lowest on ties)
   always_comb begin
      found       = 1'b0;
      have_empty  = 1'b0;
      have_victim = 1'b0;
      hit_w       = '0;
      empty_w     = '0;
      victim_w    = '0;
      victim_age  = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < int'(nw) && !found) begin
            if (!vld[w]) begin
               empty_w    = WI_W'(w);
               have_empty = 1'b1;
            end else if (tg[w] == tag_ff) begin
               hit_w = WI_W'(w);
               found = 1'b1;
            end else if (!have_victim || ag[w] > victim_age) begin
               victim_age  = ag[w];
               victim_w    = WI_W'(w);
               have_victim = 1'b1;
            end
         end
      end
      acc_hit   = found;
      acc_evict = !found && !have_empty;
      if (found) begin
         chosen_w = hit_w;
      end else if (have_empty) begin
         chosen_w = empty_w;
      end else begin
         chosen_w = victim_w;
      end
      bounded = vld[chosen_w];
      bound   = ag[chosen_w];
   end

   // new row: bump younger ages, chosen way becomes newest
   always_comb begin
      ram_wr_data = ram_rd_data;
      for (int w = 0; w < MAX_WAYS; w++) begin
         ram_wr_data[w*WAY_W + AGE_W + TAG_W] = vld[w];
         if (w < int'(nw)) begin
            if (WI_W'(w) == chosen_w) begin
               ram_wr_data[w*WAY_W +: AGE_W]                = '0;
               ram_wr_data[w*WAY_W + AGE_W +: TAG_W]        = tag_ff;
               ram_wr_data[w*WAY_W + AGE_W + TAG_W]         = 1'b1;
            end else if (vld[w] && (!bounded || ag[w] < bound) && ag[w] < AGE_MAX) begin
               ram_wr_data[w*WAY_W +: AGE_W] = ag[w] + AGE_W'(1);
            end
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sacache_pkg::ST_IDLE;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      pending_in  = pending_ff;
      busy        = 1'b1;
      ram_rd_en   = 1'b0;
      ram_rd_addr = set_ff;
      ram_wr_en   = 1'b0;
      case (state_ff)
         sacache_pkg::ST_IDLE: begin
            busy        = 1'b0;
            ram_rd_addr = set_in;
            if (start) begin
               ram_rd_en = 1'b1;
               case (sacache_pkg::op_type'(req_op))
                  sacache_pkg::OP_LOAD,
                  sacache_pkg::OP_STORE: begin
                     state_in   = sacache_pkg::ST_EVAL;
                     pending_in = 1'b0;
                  end
                  sacache_pkg::OP_MODIFY: begin
                     state_in   = sacache_pkg::ST_EVAL;
                     pending_in = 1'b1;
                  end
                  default: state_in = sacache_pkg::ST_IDLE;
               endcase
            end
         end
         sacache_pkg::ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = sacache_pkg::ST_EVAL;
         end
         sacache_pkg::ST_EVAL: begin
            ram_wr_en  = 1'b1;
            pending_in = 1'b0;
            state_in   = pending_ff ? sacache_pkg::ST_READ : sacache_pkg::ST_IDLE;
         end
         default: state_in = sacache_pkg::ST_IDLE;
      endcase
   end

   // latch the access address on accept
   always_ff @(posedge clock) begin
      if (state_ff == sacache_pkg::ST_IDLE && start) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
   end

   // row valid flops, counters, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff   <= '0;
         hit_count_ff   <= '0;
         miss_count_ff  <= '0;
         evict_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= ram_wr_en;
         if (ram_wr_en) begin
            row_valid_ff[set_ff] <= 1'b1;
            if (acc_hit) begin
               if (hit_count_ff != '1) hit_count_ff <= hit_count_ff + 32'd1;
            end else begin
               if (miss_count_ff != '1) miss_count_ff <= miss_count_ff + 32'd1;
            end
            if (acc_evict && evict_count_ff != '1) begin
               evict_count_ff <= evict_count_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         rsp_hit_ff     <= acc_hit;
         rsp_evicted_ff <= acc_evict;
         rsp_last_ff    <= !pending_ff;
      end
   end

   sacache_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (set_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_hit_total      = hit_count_ff;
   assign rsp_miss_total     = miss_count_ff;
   assign rsp_eviction_total = evict_count_ff;

`ifndef SYNTHESIS
   a_eval_gives_item: assert property (@(posedge clock) disable iff (reset)
      state_ff == sacache_pkg::ST_EVAL |=> rsp_valid)
      else $error("evaluation cycle did not produce an item");

   a_item_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

   a_hit_excl_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("item flagged both hit and eviction");

   a_modify_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> ##2 (rsp_valid && rsp_last))
      else $error("second access of modify missing");
`endif

endmodule

`default_nettype wire
